### src/polygon_clip_to_rectangle_macros.svh
// Assertion macros shared by the polygon clipper RTL.
`ifndef POLYGON_CLIP_TO_RECTANGLE_MACROS_SVH
`define POLYGON_CLIP_TO_RECTANGLE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PCTR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define PCTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/pctr_pkg.sv
// Types, constants and helpers for the polygon clipper.
package pctr_pkg;

  localparam int COORD_BITS  = 16;
  localparam int DIFF_BITS   = COORD_BITS + 1;
  localparam int PROD_BITS   = 2 * DIFF_BITS;
  localparam int CNT_BITS    = $clog2(PROD_BITS);
  localparam int NUM_STAGES  = 4;
  localparam int STAGE_BITS  = 3;
  localparam int STACK_DEPTH = 8;
  localparam int PTR_BITS    = $clog2(STACK_DEPTH);
  localparam int SP_BITS     = PTR_BITS + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  quo_t;

  typedef enum logic [1:0] {
    REG_XMIN = 2'd0,
    REG_YMIN = 2'd1,
    REG_XMAX = 2'd2,
    REG_YMAX = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE, S_POP, S_PROC, S_EDGE, S_DIV, S_EMIT, S_CLOSE, S_FINAL
  } seq_state_t;

  typedef enum logic [1:0] {
    MD_IDLE, MD_MUL, MD_DIV
  } md_state_t;

  // request to the shared multiply-divide unit: a*b/d
  typedef struct packed {
    logic  start;
    diff_t a;
    diff_t b;
    diff_t d;
  } md_req_t;

  typedef struct packed {
    logic done;
    quo_t quo;
  } md_rsp_t;

  function automatic diff_t to_diff(coord_t c);
    return diff_t'({c[COORD_BITS-1], c});
  endfunction

endpackage

### src/polygon_clip_to_rectangle.sv
// Polygon clipper top level: boundary sequencer, window registers, output register.
// Clips a polygon, one vertex per request, against the window through four
// boundary stages (left, right, bottom, top); boundary points count as inside.
// A vertex runs through a small work stack: each stage visit passes through the
// pop and process states, and each crossing point also waits on the shared
// multiply-divide unit (one product, then 34 restoring divide steps, one bit a
// cycle, then a registered done flag hands back the quotient). A closing vertex
// also walks the closing edge of each stage, after its own stage visits.
// in_stall is high while a vertex is in work. Each clipped vertex is delivered
// once the next one is known; the last carries out_polygon_end, and an empty
// result gives one request with out_polygon_empty set and zero coordinates.
`include "polygon_clip_to_rectangle_macros.svh"

module polygon_clip_to_rectangle (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  pctr_pkg::cfg_idx_t     cfg_index,
  input  pctr_pkg::coord_t       cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  pctr_pkg::coord_t       in_vertex_x,
  input  pctr_pkg::coord_t       in_vertex_y,
  input  logic                   in_final_vertex,
  output logic                   out_valid,
  input  logic                   out_stall,
  output pctr_pkg::coord_t       out_x,
  output pctr_pkg::coord_t       out_y,
  output logic                   out_polygon_end,
  output logic                   out_polygon_empty
);

  localparam int NS = pctr_pkg::NUM_STAGES;
  localparam int SD = pctr_pkg::STACK_DEPTH;

  pctr_pkg::seq_state_t state_r, state_nxt;
  pctr_pkg::coord_t xmin_r, ymin_r, xmax_r, ymax_r;

  // work stack of pending stage visits
  logic [pctr_pkg::STAGE_BITS-1:0] stk_s_r [SD];
  logic [pctr_pkg::STAGE_BITS-1:0] stk_s_nxt [SD];
  pctr_pkg::coord_t stk_x_r [SD], stk_x_nxt [SD], stk_y_r [SD], stk_y_nxt [SD];
  logic [pctr_pkg::SP_BITS-1:0] sp_r, sp_nxt;
  logic [pctr_pkg::PTR_BITS-1:0] top_ptr;

  // per-stage state
  pctr_pkg::coord_t first_x_r [NS], first_x_nxt [NS], first_y_r [NS], first_y_nxt [NS];
  pctr_pkg::coord_t prev_x_r [NS], prev_x_nxt [NS], prev_y_r [NS], prev_y_nxt [NS];
  logic [NS-1:0] started_r, started_nxt;
  logic [1:0] idx;

  // current visit, edge and crossing
  logic [pctr_pkg::STAGE_BITS-1:0] cur_s_r, cur_s_nxt;
  pctr_pkg::coord_t cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [1:0] e_s_r, e_s_nxt;
  pctr_pkg::coord_t px_r, px_nxt, py_r, py_nxt, qx_r, qx_nxt, qy_r, qy_nxt;
  pctr_pkg::coord_t c_r, c_nxt, base_r, base_nxt;
  logic final_r, final_nxt;
  logic [pctr_pkg::STAGE_BITS-1:0] cs_r, cs_nxt;

  // held result vertex
  logic any_r, any_nxt;
  pctr_pkg::coord_t pend_x_r, pend_x_nxt, pend_y_r, pend_y_nxt;

  // output register
  logic out_valid_r, out_valid_nxt, out_end_r, out_end_nxt, out_empty_r, out_empty_nxt;
  pctr_pkg::coord_t out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic out_free;

  pctr_pkg::md_req_t md_req;
  pctr_pkg::md_rsp_t md_rsp;
  logic ip, iq;
  pctr_pkg::coord_t edge_c, cross_v;

  pctr_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != pctr_pkg::S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign top_ptr   = pctr_pkg::PTR_BITS'(sp_r - 1'b1);
  assign idx       = (state_r == pctr_pkg::S_CLOSE) ? cs_r[1:0] : cur_s_r[1:0];

  // inside tests and boundary value of the edge's stage
  always_comb begin
    case (e_s_r)
      2'd0: begin
        ip = px_r >= xmin_r;
        iq = qx_r >= xmin_r;
        edge_c = xmin_r;
      end
      2'd1: begin
        ip = px_r <= xmax_r;
        iq = qx_r <= xmax_r;
        edge_c = xmax_r;
      end
      2'd2: begin
        ip = py_r >= ymin_r;
        iq = qy_r >= ymin_r;
        edge_c = ymin_r;
      end
      default: begin
        ip = py_r <= ymax_r;
        iq = qy_r <= ymax_r;
        edge_c = ymax_r;
      end
    endcase
  end

  // operands of the crossing: a*b/d added to base
  always_comb begin
    md_req.start = 1'b0;
    if (!e_s_r[1]) begin
      md_req.a = pctr_pkg::diff_t'(pctr_pkg::to_diff(qy_r) - pctr_pkg::to_diff(py_r));
      md_req.b = pctr_pkg::diff_t'(pctr_pkg::to_diff(edge_c) - pctr_pkg::to_diff(px_r));
      md_req.d = pctr_pkg::diff_t'(pctr_pkg::to_diff(qx_r) - pctr_pkg::to_diff(px_r));
    end else begin
      md_req.a = pctr_pkg::diff_t'(pctr_pkg::to_diff(qx_r) - pctr_pkg::to_diff(px_r));
      md_req.b = pctr_pkg::diff_t'(pctr_pkg::to_diff(edge_c) - pctr_pkg::to_diff(py_r));
      md_req.d = pctr_pkg::diff_t'(pctr_pkg::to_diff(qy_r) - pctr_pkg::to_diff(py_r));
    end
    if (state_r == pctr_pkg::S_EDGE && ip != iq) begin
      md_req.start = 1'b1;
    end
  end

  assign cross_v = pctr_pkg::coord_t'(pctr_pkg::quo_t'(base_r) + md_rsp.quo);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    stk_s_nxt = stk_s_r;
    stk_x_nxt = stk_x_r;
    stk_y_nxt = stk_y_r;
    sp_nxt = sp_r;
    first_x_nxt = first_x_r;
    first_y_nxt = first_y_r;
    prev_x_nxt = prev_x_r;
    prev_y_nxt = prev_y_r;
    started_nxt = started_r;
    cur_s_nxt = cur_s_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    e_s_nxt = e_s_r;
    px_nxt = px_r;
    py_nxt = py_r;
    qx_nxt = qx_r;
    qy_nxt = qy_r;
    c_nxt = c_r;
    base_nxt = base_r;
    final_nxt = final_r;
    cs_nxt = cs_r;
    any_nxt = any_r;
    pend_x_nxt = pend_x_r;
    pend_y_nxt = pend_y_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_x_nxt = out_x_r;
    out_y_nxt = out_y_r;
    out_end_nxt = out_end_r;
    out_empty_nxt = out_empty_r;
    case (state_r)
      pctr_pkg::S_IDLE: begin
        if (in_valid) begin
          stk_s_nxt[0] = '0;
          stk_x_nxt[0] = in_vertex_x;
          stk_y_nxt[0] = in_vertex_y;
          sp_nxt = pctr_pkg::SP_BITS'(1);
          final_nxt = in_final_vertex;
          cs_nxt = '0;
          state_nxt = pctr_pkg::S_POP;
        end
      end
      pctr_pkg::S_POP: begin
        if (sp_r == '0) begin
          state_nxt = final_r ? pctr_pkg::S_CLOSE : pctr_pkg::S_IDLE;
        end else begin
          cur_s_nxt = stk_s_r[top_ptr];
          cur_x_nxt = stk_x_r[top_ptr];
          cur_y_nxt = stk_y_r[top_ptr];
          sp_nxt = sp_r - 1'b1;
          state_nxt = pctr_pkg::S_PROC;
        end
      end
      pctr_pkg::S_PROC: begin
        if (cur_s_r == pctr_pkg::STAGE_BITS'(NS)) begin
          // result stage: hold the vertex, release the older one
          if (any_r) begin
            state_nxt = pctr_pkg::S_EMIT;
          end else begin
            pend_x_nxt = cur_x_r;
            pend_y_nxt = cur_y_r;
            any_nxt = 1'b1;
            state_nxt = pctr_pkg::S_POP;
          end
        end else if (!started_r[idx]) begin
          started_nxt[idx] = 1'b1;
          first_x_nxt[idx] = cur_x_r;
          first_y_nxt[idx] = cur_y_r;
          prev_x_nxt[idx] = cur_x_r;
          prev_y_nxt[idx] = cur_y_r;
          state_nxt = pctr_pkg::S_POP;
        end else begin
          e_s_nxt = idx;
          px_nxt = prev_x_r[idx];
          py_nxt = prev_y_r[idx];
          qx_nxt = cur_x_r;
          qy_nxt = cur_y_r;
          prev_x_nxt[idx] = cur_x_r;
          prev_y_nxt[idx] = cur_y_r;
          state_nxt = pctr_pkg::S_EDGE;
        end
      end
      pctr_pkg::S_EDGE: begin
        // push the end point first so the crossing is visited before it
        if (iq) begin
          stk_s_nxt[sp_r[pctr_pkg::PTR_BITS-1:0]] = pctr_pkg::STAGE_BITS'(e_s_r) + 1'b1;
          stk_x_nxt[sp_r[pctr_pkg::PTR_BITS-1:0]] = qx_r;
          stk_y_nxt[sp_r[pctr_pkg::PTR_BITS-1:0]] = qy_r;
          sp_nxt = sp_r + 1'b1;
        end
        c_nxt = edge_c;
        base_nxt = e_s_r[1] ? px_r : py_r;
        state_nxt = (ip != iq) ? pctr_pkg::S_DIV : pctr_pkg::S_POP;
      end
      pctr_pkg::S_DIV: begin
        if (md_rsp.done) begin
          stk_s_nxt[sp_r[pctr_pkg::PTR_BITS-1:0]] = pctr_pkg::STAGE_BITS'(e_s_r) + 1'b1;
          stk_x_nxt[sp_r[pctr_pkg::PTR_BITS-1:0]] = e_s_r[1] ? cross_v : c_r;
          stk_y_nxt[sp_r[pctr_pkg::PTR_BITS-1:0]] = e_s_r[1] ? c_r : cross_v;
          sp_nxt = sp_r + 1'b1;
          state_nxt = pctr_pkg::S_POP;
        end
      end
      pctr_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt = pend_x_r;
          out_y_nxt = pend_y_r;
          out_end_nxt = 1'b0;
          out_empty_nxt = 1'b0;
          pend_x_nxt = cur_x_r;
          pend_y_nxt = cur_y_r;
          state_nxt = pctr_pkg::S_POP;
        end
      end
      pctr_pkg::S_CLOSE: begin
        // walk the closing edge of each stage in turn
        if (cs_r == pctr_pkg::STAGE_BITS'(NS)) begin
          state_nxt = pctr_pkg::S_FINAL;
        end else begin
          cs_nxt = cs_r + 1'b1;
          if (started_r[idx]) begin
            e_s_nxt = idx;
            px_nxt = prev_x_r[idx];
            py_nxt = prev_y_r[idx];
            qx_nxt = first_x_r[idx];
            qy_nxt = first_y_r[idx];
            started_nxt[idx] = 1'b0;
            state_nxt = pctr_pkg::S_EDGE;
          end
        end
      end
      pctr_pkg::S_FINAL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt = any_r ? pend_x_r : '0;
          out_y_nxt = any_r ? pend_y_r : '0;
          out_end_nxt = 1'b1;
          out_empty_nxt = !any_r;
          any_nxt = 1'b0;
          pend_x_nxt = '0;
          pend_y_nxt = '0;
          state_nxt = pctr_pkg::S_IDLE;
        end
      end
      default: state_nxt = pctr_pkg::S_IDLE;
    endcase
  end

  // state register and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pctr_pkg::S_IDLE;
      sp_r <= '0;
      started_r <= '0;
      any_r <= 1'b0;
      final_r <= 1'b0;
      cs_r <= '0;
      out_valid_r <= 1'b0;
      pend_x_r <= '0;
      pend_y_r <= '0;
      for (int i = 0; i < NS; i++) begin
        first_x_r[i] <= '0;
        first_y_r[i] <= '0;
        prev_x_r[i] <= '0;
        prev_y_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      sp_r <= sp_nxt;
      started_r <= started_nxt;
      any_r <= any_nxt;
      final_r <= final_nxt;
      cs_r <= cs_nxt;
      out_valid_r <= out_valid_nxt;
      pend_x_r <= pend_x_nxt;
      pend_y_r <= pend_y_nxt;
      first_x_r <= first_x_nxt;
      first_y_r <= first_y_nxt;
      prev_x_r <= prev_x_nxt;
      prev_y_r <= prev_y_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    stk_s_r <= stk_s_nxt;
    stk_x_r <= stk_x_nxt;
    stk_y_r <= stk_y_nxt;
    cur_s_r <= cur_s_nxt;
    cur_x_r <= cur_x_nxt;
    cur_y_r <= cur_y_nxt;
    e_s_r <= e_s_nxt;
    px_r <= px_nxt;
    py_r <= py_nxt;
    qx_r <= qx_nxt;
    qy_r <= qy_nxt;
    c_r <= c_nxt;
    base_r <= base_nxt;
    out_x_r <= out_x_nxt;
    out_y_r <= out_y_nxt;
    out_end_r <= out_end_nxt;
    out_empty_r <= out_empty_nxt;
  end

  // window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xmin_r <= {1'b1, {(pctr_pkg::COORD_BITS-1){1'b0}}};
      ymin_r <= {1'b1, {(pctr_pkg::COORD_BITS-1){1'b0}}};
      xmax_r <= {1'b0, {(pctr_pkg::COORD_BITS-1){1'b1}}};
      ymax_r <= {1'b0, {(pctr_pkg::COORD_BITS-1){1'b1}}};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pctr_pkg::REG_XMIN: xmin_r <= cfg_data;
        pctr_pkg::REG_YMIN: ymin_r <= cfg_data;
        pctr_pkg::REG_XMAX: xmax_r <= cfg_data;
        pctr_pkg::REG_YMAX: ymax_r <= cfg_data;
        default: xmin_r <= xmin_r;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_x             = out_x_r;
  assign out_y             = out_y_r;
  assign out_polygon_end   = out_end_r;
  assign out_polygon_empty = out_empty_r;

  `PCTR_ASSERT_NOW(a_idle_stack_empty, state_r == pctr_pkg::S_IDLE, sp_r == '0, "stack not empty at idle")
  `PCTR_ASSERT_NOW(a_stack_bound, 1'b1, sp_r <= pctr_pkg::SP_BITS'(SD), "work stack overflow")
  `PCTR_ASSERT_NEXT(a_final_clears, state_r == pctr_pkg::S_FINAL && out_free, !any_r && out_valid_r && out_end_r, "close did not flush held vertex")

endmodule

### src/pctr_muldiv.sv
// Shared multiply then restoring divide unit, one quotient bit per cycle.
module pctr_muldiv (
  input  logic              clk,
  input  logic              rst_n,
  input  pctr_pkg::md_req_t req,
  output pctr_pkg::md_rsp_t rsp
);

  localparam int W = pctr_pkg::DIFF_BITS;
  localparam int P = pctr_pkg::PROD_BITS;

  pctr_pkg::md_state_t state_r, state_nxt;
  logic [W-1:0] ua_r, ua_nxt, ub_r, ub_nxt, ud_r, ud_nxt;
  logic [P-1:0] dvd_r, dvd_nxt;
  logic [W-1:0] rem_r, rem_nxt;
  logic [pctr_pkg::CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic neg_r, neg_nxt;
  logic done_r, done_nxt;
  logic [W:0] rem_sh;
  logic ge;

  // one restoring step
  assign rem_sh = {rem_r, dvd_r[P-1]};
  assign ge     = rem_sh >= {1'b0, ud_r};

  always_comb begin
    state_nxt = state_r;
    ua_nxt = ua_r;
    ub_nxt = ub_r;
    ud_nxt = ud_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    done_nxt = 1'b0;
    case (state_r)
      pctr_pkg::MD_IDLE: begin
        if (req.start) begin
          ua_nxt = req.a[W-1] ? W'(-req.a) : W'(req.a);
          ub_nxt = req.b[W-1] ? W'(-req.b) : W'(req.b);
          ud_nxt = req.d[W-1] ? W'(-req.d) : W'(req.d);
          neg_nxt = (req.a[W-1] ^ req.b[W-1]) ^ req.d[W-1];
          state_nxt = pctr_pkg::MD_MUL;
        end
      end
      pctr_pkg::MD_MUL: begin
        dvd_nxt = ua_r * ub_r;
        rem_nxt = '0;
        cnt_nxt = '0;
        state_nxt = pctr_pkg::MD_DIV;
      end
      pctr_pkg::MD_DIV: begin
        rem_nxt = ge ? W'(rem_sh - {1'b0, ud_r}) : rem_sh[W-1:0];
        dvd_nxt = {dvd_r[P-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == pctr_pkg::CNT_BITS'(P - 1)) begin
          done_nxt = 1'b1;
          state_nxt = pctr_pkg::MD_IDLE;
        end
      end
      default: state_nxt = pctr_pkg::MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pctr_pkg::MD_IDLE;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r <= done_nxt;
    end
    ua_r <= ua_nxt;
    ub_r <= ub_nxt;
    ud_r <= ud_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = neg_r ? pctr_pkg::quo_t'(-dvd_r) : pctr_pkg::quo_t'(dvd_r);

endmodule
